// ===== design/enl_pkg.sv =====
// ----------------------------------------------------------------------------
// Entity name and code lookup: shared definitions
// Command and status codes, name helpers and default sizes.
// ----------------------------------------------------------------------------
package enl_pkg;

	localparam int TableEntriesDef = 256;
	localparam int NameCharsDef    = 10;

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_FNAME  = 2'd2,
		CMD_FCODE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOTFOUND = 2'd1,
		ST_FULL     = 2'd2
	} status_t;

	// Zero every character after the first zero one, or at or beyond nchars.
	function automatic logic [79:0] norm_name(input logic [79:0] n, input int nchars);
		logic [79:0] r;
		logic        ended;
		r = n;
		ended = 1'b0;
		for (int i = 0; i < 10; i++) begin
			if (i >= nchars || n[79-8*i -: 8] == 8'd0)
				ended = 1'b1;
			if (ended)
				r[79-8*i -: 8] = 8'd0;
		end
		return r;
	endfunction

	// Fold capitals to lower case, character by character.
	function automatic logic [79:0] fold_name(input logic [79:0] n);
		logic [79:0] r;
		logic [7:0]  c;
		r = n;
		for (int i = 0; i < 10; i++) begin
			c = n[79-8*i -: 8];
			if (c >= 8'h41 && c <= 8'h5A)
				r[79-8*i -: 8] = c + 8'd32;
		end
		return r;
	endfunction

endpackage

// ===== design/entity_name_and_code_lookup.sv =====
// ----------------------------------------------------------------------------
// Entity name and code lookup
// Table of named entities with sorted name and code orders, searched in halves.
// ----------------------------------------------------------------------------
//
// Channel  | Handshake           | Word
// ---------+---------------------+----------------------------------------------
// command  | start high, busy low | cmd, name_low, name_high, code_point, payload
// result   | done strobe, 1 cycle | status, found_*, entry_total
//
// A clear passes through the reply state only, and done strobes in the cycle after it.
// A find runs the halving steps of the search, about log2(entries)+1 of them,
// each a midpoint, an order read and an entry read, then fetches and checks the
// first candidate and replies. An insert runs two such searches, in name order
// and then in code order, moves each order list up by one place, one entry at a
// time with a read and a write, and writes the new place. Reset empties the
// table at once; the stores need no clearing pass. The receiver cannot stall;
// busy holds commands.
//
module entity_name_and_code_lookup #(
	parameter int TABLE_ENTRIES = enl_pkg::TableEntriesDef,
	parameter int NAME_CHARS    = enl_pkg::NameCharsDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  cmd,
	input  logic [63:0] name_low,
	input  logic [15:0] name_high,
	input  logic [15:0] code_point,
	input  logic [31:0] payload,
	output logic        done,
	output logic [1:0]  status,
	output logic [63:0] found_name_low,
	output logic [15:0] found_name_high,
	output logic [15:0] found_code,
	output logic [31:0] found_payload,
	output logic [8:0]  entry_total
);
	import enl_pkg::*;

	localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW = $clog2(TABLE_ENTRIES + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_PROBE, S_ORD, S_ENT, S_CHECK, S_HITRD, S_HIT,
		S_SHRD, S_SHWR, S_PUT, S_REPLY
	} state_t;

	// Entry store, written in arrival order.
	logic [79:0] ent_name_mem [TABLE_ENTRIES];
	logic [15:0] ent_code_mem [TABLE_ENTRIES];
	logic [31:0] ent_pay_mem  [TABLE_ENTRIES];
	// Sorted order lists: entry numbers.
	logic [AW-1:0] name_ord_mem [TABLE_ENTRIES];
	logic [AW-1:0] code_ord_mem [TABLE_ENTRIES];

	state_t        state_q;
	cmd_t          cmd_q;
	logic          pass_q;          // insert: 0 name order, 1 code order
	logic [79:0]   key_q;           // folded key
	logic [79:0]   nname_q;         // normalised name
	logic [15:0]   code_q;
	logic [31:0]   pay_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] lo_q, hi_q, pos_q;
	logic [CW-1:0] mv_q;            // shift cursor
	logic [AW-1:0] ord_rd_q;        // registered order read
	logic [79:0]   ename_rd_q;
	logic [15:0]   ecode_rd_q;
	logic [31:0]   epay_rd_q;
	logic [AW-1:0] ord_addr, ent_addr;
	logic          ord_we, ent_we;
	logic [AW-1:0] ord_wa, ord_wd;
	logic [CW-1:0] mid;
	logic          ent_less, ent_eq;

	assign busy = (state_q != S_IDLE);
	assign mid  = CW'((({1'b0, lo_q} + {1'b0, hi_q}) >> 1));

	// Compare of the fetched entry against the key, in the active order.
	always_comb begin
		logic [79:0] f;
		f = fold_name(ename_rd_q);
		if ((cmd_q == CMD_FCODE) || (cmd_q == CMD_INSERT && pass_q)) begin
			ent_less = ecode_rd_q < code_q;
			ent_eq   = ecode_rd_q == code_q;
		end else begin
			ent_less = f < key_q;
			ent_eq   = f == key_q;
		end
	end

	// Order read address: probe midpoint, shift cursor less one, or lower bound.
	always_comb begin
		ord_addr = AW'(mid);
		if (state_q == S_SHRD)
			ord_addr = AW'(mv_q - CW'(1));
		else if (state_q == S_CHECK || state_q == S_HITRD)
			ord_addr = AW'(lo_q);
	end
	assign ent_addr = ord_rd_q;

	always_comb begin
		ord_we = 1'b0;
		ord_wa = AW'(mv_q);
		ord_wd = ord_rd_q;
		if (state_q == S_SHWR) begin
			ord_we = 1'b1;
		end else if (state_q == S_PUT) begin
			ord_we = 1'b1;
			ord_wa = AW'(pos_q);
			ord_wd = AW'(count_q);
		end
	end
	assign ent_we = (state_q == S_PUT) && pass_q;

	always_ff @(posedge clk) begin
		if (ord_we) begin
			if (pass_q)
				code_ord_mem[ord_wa] <= ord_wd;
			else
				name_ord_mem[ord_wa] <= ord_wd;
		end
		ord_rd_q <= pass_q || cmd_q == CMD_FCODE ? code_ord_mem[ord_addr]
			: name_ord_mem[ord_addr];
		if (ent_we) begin
			ent_name_mem[AW'(count_q)] <= nname_q;
			ent_code_mem[AW'(count_q)] <= code_q;
			ent_pay_mem[AW'(count_q)]  <= pay_q;
		end
		ename_rd_q <= ent_name_mem[ent_addr];
		ecode_rd_q <= ent_code_mem[ent_addr];
		epay_rd_q  <= ent_pay_mem[ent_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			count_q         <= '0;
			done            <= 1'b0;
			status          <= ST_OK;
			entry_total     <= '0;
			found_name_low  <= '0;
			found_name_high <= '0;
			found_code      <= '0;
			found_payload   <= '0;
			cmd_q           <= CMD_CLEAR;
			pass_q          <= 1'b0;
			lo_q            <= '0;
			hi_q            <= '0;
			pos_q           <= '0;
			mv_q            <= '0;
			key_q           <= '0;
			nname_q         <= '0;
			code_q          <= '0;
			pay_q           <= '0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q   <= cmd_t'(cmd);
						nname_q <= norm_name({name_low, name_high}, NAME_CHARS);
						key_q   <= fold_name(norm_name({name_low, name_high}, NAME_CHARS));
						code_q  <= code_point;
						pay_q   <= payload;
						pass_q  <= (cmd_t'(cmd) == CMD_FCODE);
						lo_q    <= '0;
						hi_q    <= count_q;
						status          <= ST_OK;
						found_name_low  <= '0;
						found_name_high <= '0;
						found_code      <= '0;
						found_payload   <= '0;
						case (cmd_t'(cmd))
							CMD_CLEAR: begin
								count_q <= '0;
								state_q <= S_REPLY;
							end
							CMD_INSERT: begin
								if (count_q >= CW'(TABLE_ENTRIES)) begin
									status  <= ST_FULL;
									state_q <= S_REPLY;
								end else begin
									state_q <= S_PROBE;
								end
							end
							default: state_q <= S_PROBE;
						endcase
					end
				end
				S_PROBE: begin
					if (lo_q < hi_q)
						state_q <= S_ORD;
					else if (cmd_q == CMD_INSERT) begin
						pos_q   <= lo_q;
						mv_q    <= count_q;
						state_q <= (count_q > lo_q) ? S_SHRD : S_PUT;
					end else
						state_q <= S_CHECK;
				end
				S_ORD: state_q <= S_ENT;      // order entry read, now entry
				S_ENT: begin
					// ename_rd_q now valid; upper bound for insert, lower for find
					if (ent_less || (cmd_q == CMD_INSERT && ent_eq))
						lo_q <= mid + CW'(1);
					else
						hi_q <= mid;
					state_q <= S_PROBE;
				end
				S_CHECK: begin
					if (lo_q < count_q)
						state_q <= S_HITRD;
					else begin
						status  <= ST_NOTFOUND;
						state_q <= S_REPLY;
					end
				end
				S_HITRD: state_q <= S_HIT;
				S_HIT: begin
					if (ent_eq) begin
						found_name_low  <= ename_rd_q[79:16];
						found_name_high <= ename_rd_q[15:0];
						found_code      <= ecode_rd_q;
						found_payload   <= epay_rd_q;
					end else
						status <= ST_NOTFOUND;
					state_q <= S_REPLY;
				end
				S_SHRD: state_q <= S_SHWR;
				S_SHWR: begin
					mv_q    <= mv_q - CW'(1);
					state_q <= (mv_q - CW'(1) > pos_q) ? S_SHRD : S_PUT;
				end
				S_PUT: begin
					if (!pass_q) begin
						pass_q  <= 1'b1;
						lo_q    <= '0;
						hi_q    <= count_q;
						state_q <= S_PROBE;
					end else begin
						found_name_low  <= nname_q[79:16];
						found_name_high <= nname_q[15:0];
						found_code      <= code_q;
						found_payload   <= pay_q;
						count_q         <= count_q + CW'(1);
						state_q         <= S_REPLY;
					end
				end
				S_REPLY: begin
					done        <= 1'b1;
					entry_total <= 9'(count_q);
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_ENTRIES)) else $error("entry count above depth");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result while busy");
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_FULL) |-> entry_total == 9'(TABLE_ENTRIES))
		else $error("full reported below depth");
`endif

endmodule
